// File: hw/rtl/address_hit_counter_table_core_assert.svh
// assertion macros for the address hit counter table core
`ifndef ADDRESS_HIT_COUNTER_TABLE_CORE_ASSERT_SVH
`define ADDRESS_HIT_COUNTER_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AHCT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ahct implication check failed");

// next-cycle implication, checked out of reset
`define AHCT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ahct next-cycle check failed");

`endif

// File: hw/rtl/ahct_pkg.sv
// shared types and constants for the address hit counter table
package ahct_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int FILL_W  = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 31;

    localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(ENTRIES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_BLOCK = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic               blocked;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] hit_count;
        logic [1:0]         status;
    } result_t;

endpackage

// File: hw/rtl/ahct_table.sv
// entry memory: one write port, one registered read port
module ahct_table
(
    input  logic              clk,
    input  ahct_pkg::mem_req_t mem_req,
    output ahct_pkg::entry_t  rd_entry
);

    ahct_pkg::entry_t entry_mem_reg [ahct_pkg::ENTRIES];
    ahct_pkg::entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            entry_mem_reg[mem_req.wr_addr] <= mem_req.wr_data;
        end
        rd_entry_reg <= entry_mem_reg[mem_req.rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

// File: hw/rtl/ahct_ctrl.sv
// scan, update and append sequencer for the address table
`include "address_hit_counter_table_core_assert.svh"

module ahct_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     command,
    input  logic [ahct_pkg::KEY_W-1:0]     ip_addr,
    input  logic [ahct_pkg::COUNT_W-1:0]   load_count,
    input  logic                           load_blocked,
    output ahct_pkg::mem_req_t             mem_req,
    input  ahct_pkg::entry_t               rd_entry,
    output logic                           done_valid,
    input  logic                           done_take,
    output ahct_pkg::result_t              res
);

    ahct_pkg::state_t state_reg, state_next;

    logic [ahct_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [ahct_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [ahct_pkg::COUNT_W-1:0] res_count_reg, res_count_next;
    logic [1:0]                   res_status_reg, res_status_next;

    logic [1:0]                   cmd_reg;
    logic [ahct_pkg::KEY_W-1:0]   key_reg;
    logic [ahct_pkg::COUNT_W-1:0] lcount_reg;
    logic                         lblocked_reg;

    logic                         accept;
    logic                         match;
    logic                         last;
    logic [ahct_pkg::COUNT_W-1:0] new_count;

    assign accept    = in_valid && !in_stall;
    assign match     = (rd_entry.key == key_reg);
    assign last      = (({1'b0, idx_reg} + ahct_pkg::FILL_W'(1)) == fill_reg);
    assign new_count = (rd_entry.count == ahct_pkg::COUNT_MAX) ?
                       rd_entry.count : (rd_entry.count + ahct_pkg::COUNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ahct_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (command) inside
                        ahct_pkg::CMD_LOAD:
                            state_next = ahct_pkg::S_APPEND;
                        ahct_pkg::CMD_COUNT, ahct_pkg::CMD_BLOCK:
                            state_next = (fill_reg == '0) ? ahct_pkg::S_APPEND
                                                          : ahct_pkg::S_SCAN;
                        default:
                            state_next = ahct_pkg::S_DONE;
                    endcase
                end
            end
            ahct_pkg::S_SCAN:
            begin
                if (match)
                begin
                    state_next = ahct_pkg::S_DONE;
                end
                else if (last)
                begin
                    state_next = ahct_pkg::S_APPEND;
                end
            end
            ahct_pkg::S_APPEND:
                state_next = ahct_pkg::S_DONE;
            ahct_pkg::S_DONE:
            begin
                if (done_take)
                begin
                    state_next = ahct_pkg::S_IDLE;
                end
            end
            default:
                state_next = ahct_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_stall        = 1'b1;
        idx_next        = idx_reg;
        fill_next       = fill_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        mem_req         = '0;
        unique case (state_reg)
            ahct_pkg::S_IDLE:
            begin
                in_stall        = 1'b0;
                idx_next        = '0;
                res_count_next  = '0;
                res_status_next = ahct_pkg::ST_OK;
            end
            ahct_pkg::S_SCAN:
            begin
                mem_req.rd_addr = idx_reg + ahct_pkg::IDX_W'(1);
                if (match)
                begin
                    mem_req.wr_en       = 1'b1;
                    mem_req.wr_addr     = idx_reg;
                    mem_req.wr_data.key = key_reg;
                    if (cmd_reg == ahct_pkg::CMD_COUNT)
                    begin
                        mem_req.wr_data.count   = new_count;
                        mem_req.wr_data.blocked = rd_entry.blocked;
                        res_count_next          = new_count;
                    end
                    else
                    begin
                        mem_req.wr_data.count   = rd_entry.count;
                        mem_req.wr_data.blocked = 1'b1;
                        res_count_next          = '0;
                    end
                    res_status_next = ahct_pkg::ST_OK;
                end
                else if (!last)
                begin
                    idx_next = idx_reg + ahct_pkg::IDX_W'(1);
                end
            end
            ahct_pkg::S_APPEND:
            begin
                res_count_next = '0;
                if (cmd_reg == ahct_pkg::CMD_BLOCK)
                begin
                    res_status_next = ahct_pkg::ST_NOT_FOUND;
                end
                else if (fill_reg == ahct_pkg::FILL_FULL)
                begin
                    res_status_next = ahct_pkg::ST_FULL;
                end
                else
                begin
                    mem_req.wr_en       = 1'b1;
                    mem_req.wr_addr     = fill_reg[ahct_pkg::IDX_W-1:0];
                    mem_req.wr_data.key = key_reg;
                    fill_next           = fill_reg + ahct_pkg::FILL_W'(1);
                    res_status_next     = ahct_pkg::ST_OK;
                    if (cmd_reg == ahct_pkg::CMD_COUNT)
                    begin
                        mem_req.wr_data.count   = ahct_pkg::COUNT_W'(1);
                        mem_req.wr_data.blocked = 1'b0;
                        res_count_next          = ahct_pkg::COUNT_W'(1);
                    end
                    else
                    begin
                        mem_req.wr_data.count   = lcount_reg;
                        mem_req.wr_data.blocked = lblocked_reg;
                    end
                end
            end
            ahct_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ahct_pkg::S_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            cmd_reg      <= command;
            key_reg      <= ip_addr;
            lcount_reg   <= load_count;
            lblocked_reg <= load_blocked;
        end
    end

    assign done_valid    = (state_reg == ahct_pkg::S_DONE);
    assign res.hit_count = res_count_reg;
    assign res.status    = res_status_reg;

    `AHCT_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= ahct_pkg::FILL_FULL)
    `AHCT_ASSERT_IMP(a_scan_in_range, state_reg == ahct_pkg::S_SCAN,
        {1'b0, idx_reg} < fill_reg)
    `AHCT_ASSERT_IMP(a_write_in_range, mem_req.wr_en, {1'b0, mem_req.wr_addr} <= fill_reg)
    `AHCT_ASSERT_NXT(a_fill_step, 1'b1,
        fill_reg == $past(fill_reg) || fill_reg == $past(fill_reg) + ahct_pkg::FILL_W'(1))

endmodule

// File: hw/rtl/address_hit_counter_table_core.sv
// top level of the address hit counter table
//
//  channel  dir  handshake           word
//  in       in   in_valid/in_stall   command, ip_addr, load_count, load_blocked
//  out      out  out_valid/out_stall hit_count, status
//
// count and block words scan the filled entries one per cycle through the single
// memory read port: a hit ends the scan at that entry, a miss at the last filled
// entry moves on to append; load skips the scan, unused commands go to done
// one word is in flight at a time; the next word is taken once the result is
// in the output register, which holds it under out_stall
// reset empties the table at once (fill level to zero), no clearing pass
module address_hit_counter_table_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic [ahct_pkg::KEY_W-1:0]   ip_addr,
    input  logic [ahct_pkg::COUNT_W-1:0] load_count,
    input  logic                         load_blocked,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ahct_pkg::COUNT_W-1:0] hit_count,
    output logic [1:0]                   status
);

    ahct_pkg::mem_req_t mem_req;
    ahct_pkg::entry_t   rd_entry;
    ahct_pkg::result_t  res;

    logic done_valid;
    logic done_take;
    logic out_valid_reg, out_valid_next;

    logic [ahct_pkg::COUNT_W-1:0] hit_count_reg;
    logic [1:0]                   status_reg;

    ahct_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .ip_addr      (ip_addr),
        .load_count   (load_count),
        .load_blocked (load_blocked),
        .mem_req      (mem_req),
        .rd_entry     (rd_entry),
        .done_valid   (done_valid),
        .done_take    (done_take),
        .res          (res)
    );

    ahct_table u_table
    (
        .clk      (clk),
        .mem_req  (mem_req),
        .rd_entry (rd_entry)
    );

    assign done_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_valid && done_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_take)
        begin
            hit_count_reg <= res.hit_count;
            status_reg    <= res.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_count = hit_count_reg;
    assign status    = status_reg;

endmodule
